### hdl/kmst_pkg.sv
// shared constants and types for the kruskal spanning tree weight unit
package kmst_pkg;

    localparam int MAX_NODES   = 1024;
    localparam int NODE_BITS   = $clog2(MAX_NODES);
    localparam int COUNT_BITS  = NODE_BITS + 1;
    localparam int MAX_EDGES   = 4096;
    localparam int EADDR_BITS  = $clog2(MAX_EDGES);
    localparam int ECNT_BITS   = EADDR_BITS + 1;
    localparam int WEIGHT_BITS = 16;
    localparam int KEY_BITS    = WEIGHT_BITS + 2 * NODE_BITS;
    localparam int TOTAL_BITS  = 26;
    localparam int PADDR_BITS  = 3;
    localparam int PDATA_BITS  = 32;

    localparam logic [COUNT_BITS-1:0] NODE_COUNT_RESET = COUNT_BITS'(MAX_NODES);
    // register index decoded from paddr[2]
    localparam logic REG_NODE_COUNT = 1'b0;

    typedef logic [NODE_BITS-1:0]   node_t;
    typedef logic [COUNT_BITS-1:0]  count_t;
    typedef logic [KEY_BITS-1:0]    key_t;
    typedef logic [ECNT_BITS-1:0]   ecnt_t;

    typedef struct packed {
        logic  init;
        logic  start;
        node_t node_a;
        node_t node_b;
    } uf_req_t;

    typedef struct packed {
        logic done;
        logic joined;
    } uf_rsp_t;

endpackage

### hdl/kmst_edge_if.sv
// edge input channel
interface kmst_edge_if;
    logic                                   valid;
    logic                                   ready;
    logic [kmst_pkg::NODE_BITS-1:0]         first_node;
    logic [kmst_pkg::NODE_BITS-1:0]         second_node;
    logic signed [kmst_pkg::WEIGHT_BITS-1:0] edge_weight;
    logic                                   last_edge;

    modport source (output valid, first_node, second_node, edge_weight, last_edge,
                    input ready);
    modport sink   (input valid, first_node, second_node, edge_weight, last_edge,
                    output ready);
endinterface

### hdl/kmst_result_if.sv
// result output channel
interface kmst_result_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [kmst_pkg::TOTAL_BITS-1:0] total_weight;
    logic                                   edges_dropped;

    modport source (output valid, total_weight, edges_dropped, input ready);
    modport sink   (input valid, total_weight, edges_dropped, output ready);
endinterface

### hdl/kmst_uf.sv
// union-find unit: parent and size memories, find with path compression, union by size
module kmst_uf (
    input  logic               clk,
    input  logic               rst_n,
    input  kmst_pkg::uf_req_t  req,
    output kmst_pkg::uf_rsp_t  rsp
);

    localparam logic [3:0] U_IDLE = 4'd0;
    localparam logic [3:0] U_INIT = 4'd1;
    localparam logic [3:0] U_FRD  = 4'd2;
    localparam logic [3:0] U_FCHK = 4'd3;
    localparam logic [3:0] U_CRD  = 4'd4;
    localparam logic [3:0] U_CCHK = 4'd5;
    localparam logic [3:0] U_SZA  = 4'd6;
    localparam logic [3:0] U_SZB  = 4'd7;
    localparam logic [3:0] U_LINK = 4'd8;

    kmst_pkg::node_t  parent_mem [0:kmst_pkg::MAX_NODES-1];
    kmst_pkg::count_t size_mem   [0:kmst_pkg::MAX_NODES-1];

    logic [3:0]       state_reg, state_next;
    kmst_pkg::node_t  cnt_reg, cnt_next;
    kmst_pkg::node_t  x_reg, x_next;
    kmst_pkg::node_t  y_reg, y_next;
    kmst_pkg::node_t  root_reg, root_next;
    kmst_pkg::node_t  ra_reg, ra_next;
    kmst_pkg::node_t  b_reg, b_next;
    logic             phase_reg, phase_next;
    kmst_pkg::count_t sa_reg, sa_next;
    logic             done_reg, done_next;
    logic             joined_reg, joined_next;

    kmst_pkg::node_t  p_raddr, p_waddr, p_wdata, p_rdata;
    logic             p_we;
    kmst_pkg::node_t  s_raddr, s_waddr;
    kmst_pkg::count_t s_wdata, s_rdata;
    logic             s_we;

    always_ff @(posedge clk)
    begin
        p_rdata <= parent_mem[p_raddr];
        if (p_we)
        begin
            parent_mem[p_waddr] <= p_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        s_rdata <= size_mem[s_raddr];
        if (s_we)
        begin
            size_mem[s_waddr] <= s_wdata;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        root_next   = root_reg;
        ra_next     = ra_reg;
        b_next      = b_reg;
        phase_next  = phase_reg;
        sa_next     = sa_reg;
        done_next   = 1'b0;
        joined_next = joined_reg;
        p_raddr     = x_reg;
        p_waddr     = y_reg;
        p_wdata     = root_reg;
        p_we        = 1'b0;
        s_raddr     = ra_reg;
        s_waddr     = cnt_reg;
        s_wdata     = kmst_pkg::count_t'(1);
        s_we        = 1'b0;
        unique case (state_reg)
            U_IDLE:
            begin
                if (req.init)
                begin
                    cnt_next   = '0;
                    state_next = U_INIT;
                end
                else if (req.start)
                begin
                    x_next     = req.node_a;
                    y_next     = req.node_a;
                    b_next     = req.node_b;
                    phase_next = 1'b0;
                    state_next = U_FRD;
                end
            end
            U_INIT:
            begin
                p_we     = 1'b1;
                p_waddr  = cnt_reg;
                p_wdata  = cnt_reg;
                s_we     = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == kmst_pkg::node_t'(kmst_pkg::MAX_NODES - 1))
                begin
                    done_next  = 1'b1;
                    state_next = U_IDLE;
                end
            end
            U_FRD:
            begin
                p_raddr    = x_reg;
                state_next = U_FCHK;
            end
            U_FCHK:
            begin
                if (p_rdata == x_reg)
                begin
                    root_next  = x_reg;
                    state_next = U_CRD;
                end
                else
                begin
                    x_next     = p_rdata;
                    state_next = U_FRD;
                end
            end
            U_CRD:
            begin
                p_raddr    = y_reg;
                state_next = U_CCHK;
            end
            U_CCHK:
            begin
                if (p_rdata == root_reg)
                begin
                    if (!phase_reg)
                    begin
                        ra_next    = root_reg;
                        x_next     = b_reg;
                        y_next     = b_reg;
                        phase_next = 1'b1;
                        state_next = U_FRD;
                    end
                    else if (ra_reg == root_reg)
                    begin
                        // both ends already in one set
                        done_next   = 1'b1;
                        joined_next = 1'b0;
                        state_next  = U_IDLE;
                    end
                    else
                    begin
                        state_next = U_SZA;
                    end
                end
                else
                begin
                    // point this node straight at the root
                    p_we       = 1'b1;
                    p_waddr    = y_reg;
                    p_wdata    = root_reg;
                    y_next     = p_rdata;
                    state_next = U_CRD;
                end
            end
            U_SZA:
            begin
                s_raddr    = ra_reg;
                state_next = U_SZB;
            end
            U_SZB:
            begin
                sa_next    = s_rdata;
                s_raddr    = root_reg;
                state_next = U_LINK;
            end
            U_LINK:
            begin
                p_we    = 1'b1;
                s_we    = 1'b1;
                s_wdata = kmst_pkg::count_t'(sa_reg + s_rdata);
                if (sa_reg < s_rdata)
                begin
                    p_waddr = ra_reg;
                    p_wdata = root_reg;
                    s_waddr = root_reg;
                end
                else
                begin
                    p_waddr = root_reg;
                    p_wdata = ra_reg;
                    s_waddr = ra_reg;
                end
                done_next   = 1'b1;
                joined_next = 1'b1;
                state_next  = U_IDLE;
            end
            default:
            begin
                state_next = U_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= U_IDLE;
            done_reg   <= 1'b0;
            joined_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            done_reg   <= done_next;
            joined_reg <= joined_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg   <= cnt_next;
        x_reg     <= x_next;
        y_reg     <= y_next;
        root_reg  <= root_next;
        ra_reg    <= ra_next;
        b_reg     <= b_next;
        phase_reg <= phase_next;
        sa_reg    <= sa_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.joined = joined_reg;

endmodule

### hdl/kruskal_mst_weight_unit.sv
// top level: edge store, merge sort between edge memories mem0 and mem1, kruskal scan
//
// channel      direction  handshake          payload
// edge_in      in         valid/ready        first_node, second_node, edge_weight, last_edge
// result_out   out        valid/ready        total_weight, edges_dropped
// apb          in         psel/penable/...   node_count at byte address 0
//
// edges load at one per cycle while idle; an edge with last_edge set starts the run
// run: bottom-up merge sort passes (each element read from both runs and placed by
// one compare), a reset of every union-find entry, then per edge a find on each
// endpoint with path compression and, when the roots differ, a link by size
// edge_in.ready is low for the whole run; the result waits in an output register
// reset leaves node_count at 1024 and the edge count empty; no clearing pass is needed
module kruskal_mst_weight_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    kmst_edge_if.sink                            edge_in,
    kmst_result_if.source                        result_out,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [kmst_pkg::PADDR_BITS-1:0]      paddr,
    input  logic [kmst_pkg::PDATA_BITS-1:0]      pwdata,
    output logic [kmst_pkg::PDATA_BITS-1:0]      prdata,
    output logic                                 pready
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PASS  = 4'd1;
    localparam logic [3:0] ST_BLOCK = 4'd2;
    localparam logic [3:0] ST_SRD   = 4'd3;
    localparam logic [3:0] ST_SCMP  = 4'd4;
    localparam logic [3:0] ST_INIT  = 4'd5;
    localparam logic [3:0] ST_IWAIT = 4'd6;
    localparam logic [3:0] ST_KRD   = 4'd7;
    localparam logic [3:0] ST_KEDGE = 4'd8;
    localparam logic [3:0] ST_KWAIT = 4'd9;
    localparam logic [3:0] ST_DONE  = 4'd10;

    localparam int WB = kmst_pkg::WEIGHT_BITS;
    localparam int NB = kmst_pkg::NODE_BITS;
    localparam int EB = kmst_pkg::ECNT_BITS;

    // edge memories mem0 and mem1, ping-pong between merge passes
    kmst_pkg::key_t mem0 [0:kmst_pkg::MAX_EDGES-1];
    kmst_pkg::key_t mem1 [0:kmst_pkg::MAX_EDGES-1];

    logic [3:0]       state_reg, state_next;
    kmst_pkg::count_t node_count_reg;
    kmst_pkg::ecnt_t  n_reg, n_next;             // stored edge count
    logic             drop_reg, drop_next;
    logic             src_reg, src_next;         // memory holding current order
    kmst_pkg::ecnt_t  width_reg, width_next;
    kmst_pkg::ecnt_t  lo_reg, lo_next;
    kmst_pkg::ecnt_t  mid_reg, mid_next;
    kmst_pkg::ecnt_t  hi_reg, hi_next;
    kmst_pkg::ecnt_t  i_reg, i_next;
    kmst_pkg::ecnt_t  j_reg, j_next;
    kmst_pkg::ecnt_t  k_reg, k_next;
    logic [WB-1:0]    w_reg, w_next;             // biased weight of edge in flight
    logic signed [kmst_pkg::TOTAL_BITS-1:0] sum_reg, sum_next;
    logic             out_valid_reg, out_valid_next;
    logic signed [kmst_pkg::TOTAL_BITS-1:0] out_total_reg, out_total_next;
    logic             out_drop_reg, out_drop_next;

    kmst_pkg::key_t   rd0_i, rd0_j, rd1_i, rd1_j, di, dj;
    logic [kmst_pkg::EADDR_BITS-1:0] raddr_i, raddr_j, waddr;
    kmst_pkg::key_t   wdata;
    logic             we0, we1;

    kmst_pkg::uf_req_t uf_req;
    kmst_pkg::uf_rsp_t uf_rsp;

    kmst_pkg::count_t limit;
    logic             in_take, in_ok;
    logic [EB:0]      mid_sum, hi_sum;
    kmst_pkg::ecnt_t  mid_calc;
    logic             take_j;
    logic             cfg_wr;

    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == kmst_pkg::REG_NODE_COUNT);
    assign prdata = (paddr[2] == kmst_pkg::REG_NODE_COUNT)
                    ? kmst_pkg::PDATA_BITS'(node_count_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= kmst_pkg::NODE_COUNT_RESET;
        end
        else if (cfg_wr)
        begin
            node_count_reg <= pwdata[kmst_pkg::COUNT_BITS-1:0];
        end
    end

    // edge memories: two read ports and one write port each
    always_ff @(posedge clk)
    begin
        rd0_i <= mem0[raddr_i];
        rd0_j <= mem0[raddr_j];
        if (we0)
        begin
            mem0[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rd1_i <= mem1[raddr_i];
        rd1_j <= mem1[raddr_j];
        if (we1)
        begin
            mem1[waddr] <= wdata;
        end
    end

    assign di = src_reg ? rd1_i : rd0_i;
    assign dj = src_reg ? rd1_j : rd0_j;

    kmst_uf u_uf (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (uf_req),
        .rsp   (uf_rsp)
    );

    // node count above the node capacity acts as the capacity
    assign limit   = (node_count_reg > kmst_pkg::count_t'(kmst_pkg::MAX_NODES))
                     ? kmst_pkg::count_t'(kmst_pkg::MAX_NODES) : node_count_reg;
    assign in_take = edge_in.valid && edge_in.ready;
    assign in_ok   = ({1'b0, edge_in.first_node} < limit)
                     && ({1'b0, edge_in.second_node} < limit)
                     && (n_reg < kmst_pkg::ecnt_t'(kmst_pkg::MAX_EDGES));

    assign edge_in.ready = (state_reg == ST_IDLE);

    // merge block bounds
    assign mid_sum  = {1'b0, lo_reg} + {1'b0, width_reg};
    assign mid_calc = (mid_sum < {1'b0, n_reg}) ? mid_sum[EB-1:0] : n_reg;
    assign hi_sum   = {1'b0, mid_calc} + {1'b0, width_reg};

    assign take_j = (j_reg < hi_reg) && ((i_reg >= mid_reg) || (dj < di));

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        drop_next      = drop_reg;
        src_next       = src_reg;
        width_next     = width_reg;
        lo_next        = lo_reg;
        mid_next       = mid_reg;
        hi_next        = hi_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        w_next         = w_reg;
        sum_next       = sum_reg;
        out_valid_next = out_valid_reg;
        out_total_next = out_total_reg;
        out_drop_next  = out_drop_reg;
        raddr_i        = i_reg[kmst_pkg::EADDR_BITS-1:0];
        raddr_j        = j_reg[kmst_pkg::EADDR_BITS-1:0];
        waddr          = k_reg[kmst_pkg::EADDR_BITS-1:0];
        wdata          = take_j ? dj : di;
        we0            = 1'b0;
        we1            = 1'b0;
        uf_req.init    = 1'b0;
        uf_req.start   = 1'b0;
        uf_req.node_a  = di[2*NB-1:NB];
        uf_req.node_b  = di[NB-1:0];

        if (result_out.valid && result_out.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                waddr = n_reg[kmst_pkg::EADDR_BITS-1:0];
                // sort key: biased weight, first node, second node
                wdata = {edge_in.edge_weight ^ {1'b1, {(WB-1){1'b0}}},
                         edge_in.first_node, edge_in.second_node};
                if (in_take)
                begin
                    if (in_ok)
                    begin
                        we0    = 1'b1;
                        n_next = n_reg + 1'b1;
                    end
                    else
                    begin
                        drop_next = 1'b1;
                    end
                    if (edge_in.last_edge)
                    begin
                        src_next   = 1'b0;
                        width_next = kmst_pkg::ecnt_t'(1);
                        state_next = ST_PASS;
                    end
                end
            end
            ST_PASS:
            begin
                if (width_reg >= n_reg)
                begin
                    state_next = ST_INIT;
                end
                else
                begin
                    lo_next    = '0;
                    state_next = ST_BLOCK;
                end
            end
            ST_BLOCK:
            begin
                if (lo_reg >= n_reg)
                begin
                    // pass done: output memory becomes the source
                    width_next = kmst_pkg::ecnt_t'({width_reg, 1'b0});
                    src_next   = !src_reg;
                    state_next = ST_PASS;
                end
                else
                begin
                    mid_next   = mid_calc;
                    hi_next    = (hi_sum < {1'b0, n_reg}) ? hi_sum[EB-1:0] : n_reg;
                    i_next     = lo_reg;
                    j_next     = mid_calc;
                    k_next     = lo_reg;
                    state_next = ST_SRD;
                end
            end
            ST_SRD:
            begin
                if (k_reg == hi_reg)
                begin
                    lo_next    = hi_reg;
                    state_next = ST_BLOCK;
                end
                else
                begin
                    state_next = ST_SCMP;
                end
            end
            ST_SCMP:
            begin
                we0    = src_reg;
                we1    = !src_reg;
                k_next = k_reg + 1'b1;
                if (take_j)
                begin
                    j_next = j_reg + 1'b1;
                end
                else
                begin
                    i_next = i_reg + 1'b1;
                end
                state_next = ST_SRD;
            end
            ST_INIT:
            begin
                uf_req.init = 1'b1;
                state_next  = ST_IWAIT;
            end
            ST_IWAIT:
            begin
                if (uf_rsp.done)
                begin
                    i_next     = '0;
                    sum_next   = '0;
                    state_next = ST_KRD;
                end
            end
            ST_KRD:
            begin
                if (i_reg == n_reg)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_KEDGE;
                end
            end
            ST_KEDGE:
            begin
                uf_req.start = 1'b1;
                w_next       = di[kmst_pkg::KEY_BITS-1:2*NB];
                state_next   = ST_KWAIT;
            end
            ST_KWAIT:
            begin
                if (uf_rsp.done)
                begin
                    if (uf_rsp.joined)
                    begin
                        // unbias: flip the top bit, then sign extend
                        sum_next = sum_reg + kmst_pkg::TOTAL_BITS'(
                                   $signed({~w_reg[WB-1], w_reg[WB-2:0]}));
                    end
                    i_next     = i_reg + 1'b1;
                    state_next = ST_KRD;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_out.ready)
                begin
                    out_valid_next = 1'b1;
                    out_total_next = sum_reg;
                    out_drop_next  = drop_reg;
                    n_next         = '0;
                    drop_next      = 1'b0;
                    src_next       = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            n_reg         <= '0;
            drop_reg      <= 1'b0;
            src_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            n_reg         <= n_next;
            drop_reg      <= drop_next;
            src_reg       <= src_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        width_reg     <= width_next;
        lo_reg        <= lo_next;
        mid_reg       <= mid_next;
        hi_reg        <= hi_next;
        i_reg         <= i_next;
        j_reg         <= j_next;
        k_reg         <= k_next;
        w_reg         <= w_next;
        sum_reg       <= sum_next;
        out_total_reg <= out_total_next;
        out_drop_reg  <= out_drop_next;
    end

    assign result_out.valid         = out_valid_reg;
    assign result_out.total_weight  = out_total_reg;
    assign result_out.edges_dropped = out_drop_reg;

endmodule

### sim/kruskal_mst_weight_unit_tb.sv
// testbench for the kruskal spanning tree weight unit with a self-checking scoreboard
`timescale 1ns / 100ps

module kruskal_mst_weight_unit_tb;

    // one expected spanning tree result
    typedef struct {
        logic signed [kmst_pkg::TOTAL_BITS-1:0] total_weight;
        logic                                   edges_dropped;
    } mst_result_t;

    // tracks the stored graph and predicts the tree weight at each last edge
    class mst_scoreboard;
        bit [kmst_pkg::KEY_BITS-1:0] graph_keys[$];
        mst_result_t                 pending_results[$];
        int unsigned                 node_limit;
        bit                          drop_seen;
        int                          error_count;

        function new();
            node_limit  = kmst_pkg::MAX_NODES;
            drop_seen   = 0;
            error_count = 0;
        endfunction

        function void set_node_count(logic [kmst_pkg::COUNT_BITS-1:0] value);
            node_limit = (value > kmst_pkg::MAX_NODES) ? kmst_pkg::MAX_NODES : value;
        endfunction

        function int unsigned find_root(ref int unsigned parent[kmst_pkg::MAX_NODES],
                                        input int unsigned x);
            int unsigned r;
            r = x;
            while (parent[r] != r)
                r = parent[r];
            while (parent[x] != r)
            begin
                int unsigned nxt;
                nxt = parent[x];
                parent[x] = r;
                x = nxt;
            end
            return r;
        endfunction

        function void tree_weight();
            int unsigned parent[kmst_pkg::MAX_NODES];
            int unsigned group_size[kmst_pkg::MAX_NODES];
            int unsigned ra, rb, t;
            int          sum;
            mst_result_t res;
            for (int i = 0; i < kmst_pkg::MAX_NODES; i++)
            begin
                parent[i]     = i;
                group_size[i] = 1;
            end
            sum = 0;
            graph_keys.sort();
            foreach (graph_keys[k])
            begin
                ra = find_root(parent,
                               graph_keys[k][2*kmst_pkg::NODE_BITS-1:kmst_pkg::NODE_BITS]);
                rb = find_root(parent, graph_keys[k][kmst_pkg::NODE_BITS-1:0]);
                if (ra != rb)
                begin
                    if (group_size[ra] < group_size[rb])
                    begin
                        t = ra; ra = rb; rb = t;
                    end
                    parent[rb] = ra;
                    group_size[ra] += group_size[rb];
                    // undo the sign bias of the weight field
                    sum += int'(signed'(
                           graph_keys[k][kmst_pkg::KEY_BITS-1:2*kmst_pkg::NODE_BITS]
                           ^ 16'h8000));
                end
            end
            res.total_weight  = sum[kmst_pkg::TOTAL_BITS-1:0];
            res.edges_dropped = drop_seen;
            pending_results.insert(pending_results.size(), res);
            graph_keys.delete();
            drop_seen = 0;
        endfunction

        function void note_edge(kmst_pkg::node_t a, kmst_pkg::node_t b,
                                logic signed [kmst_pkg::WEIGHT_BITS-1:0] w, logic last);
            if (a >= node_limit || b >= node_limit || graph_keys.size() >= kmst_pkg::MAX_EDGES)
                drop_seen = 1;
            else
                graph_keys.insert(graph_keys.size(), {w ^ 16'h8000, a, b});
            if (last)
                tree_weight();
        endfunction

        function void check_result(logic signed [kmst_pkg::TOTAL_BITS-1:0] tw, logic dropped);
            mst_result_t exp_res;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result total_weight=%0d edges_dropped=%0b",
                         $time, tw, dropped);
                error_count++;
                return;
            end
            exp_res = pending_results.pop_front();
            if (tw !== exp_res.total_weight)
            begin
                $display("%0t: total_weight expected %0d actual %0d",
                         $time, exp_res.total_weight, tw);
                error_count++;
            end
            if (dropped !== exp_res.edges_dropped)
            begin
                $display("%0t: edges_dropped expected %0b actual %0b",
                         $time, exp_res.edges_dropped, dropped);
                error_count++;
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic psel, penable, pwrite;
    logic [kmst_pkg::PADDR_BITS-1:0] paddr;
    logic [kmst_pkg::PDATA_BITS-1:0] pwdata, prdata;
    logic pready;

    kmst_edge_if   edge_if ();
    kmst_result_if res_if ();

    kruskal_mst_weight_unit i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .edge_in    (edge_if.sink),
        .result_out (res_if.source),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    mst_scoreboard sb = new();
    bit            hold_request = 0;   // asks the receiver for one long stall
    int unsigned   idle_cycles  = 0;
    localparam int unsigned WATCHDOG_LIMIT = 400000;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // receiver: random ready with short and long stalls, full-rate stretches,
    // and one long hold-off on request
    initial
    begin
        int r;
        res_if.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                res_if.ready <= 1'b0;
                repeat (5000) @(posedge clk);
                hold_request = 0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    res_if.ready <= 1'b1;
                else if (r < 92)
                    res_if.ready <= 1'b0;
                else if (r < 96)
                begin
                    res_if.ready <= 1'b0;
                    repeat ($urandom_range(20, 120)) @(posedge clk);
                end
                else
                begin
                    res_if.ready <= 1'b1;
                    repeat ($urandom_range(50, 200)) @(posedge clk);
                end
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
            sb.check_result(res_if.total_weight, res_if.edges_dropped);
    end

    // watchdog on cycles with no transaction on either channel
    always @(posedge clk)
    begin
        if ((edge_if.valid && edge_if.ready) || (res_if.valid && res_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // one edge transaction; a zero gap keeps valid high between edges
    task automatic send_edge(input kmst_pkg::node_t a, input kmst_pkg::node_t b,
                             input logic signed [kmst_pkg::WEIGHT_BITS-1:0] w,
                             input logic last, input bit no_gap = 0);
        int r;
        int unsigned gap;
        r = $urandom_range(0, 99);
        gap = 0;
        if (!no_gap)
        begin
            if (r >= 95)
                gap = $urandom_range(10, 60);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            edge_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        edge_if.first_node  <= a;
        edge_if.second_node <= b;
        edge_if.edge_weight <= w;
        edge_if.last_edge   <= last;
        edge_if.valid       <= 1'b1;
        do
            @(posedge clk);
        while (!edge_if.ready);
        sb.note_edge(a, b, w, last);
    endtask

    task automatic write_node_count(input logic [kmst_pkg::PDATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {kmst_pkg::REG_NODE_COUNT, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        sb.set_node_count(value[kmst_pkg::COUNT_BITS-1:0]);
    endtask

    // lets every expected result drain, then gives the block time to settle
    task automatic drain_results();
        edge_if.valid <= 1'b0;
        while (sb.pending_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic signed [kmst_pkg::WEIGHT_BITS-1:0] pick_weight();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'sh8000;
        else if (r == 1)
            return 16'sh7fff;
        return kmst_pkg::WEIGHT_BITS'($urandom());
    endfunction

    function automatic kmst_pkg::node_t pick_node();
        int unsigned lim;
        lim = (sb.node_limit == 0) ? 1 : sb.node_limit;
        if ($urandom_range(0, 19) == 0)
            return kmst_pkg::node_t'($urandom_range(0, kmst_pkg::MAX_NODES - 1));
        return kmst_pkg::node_t'($urandom_range(0, lim - 1));
    endfunction

    // random graphs, mostly small, a few larger ones
    task automatic random_graphs(input int unsigned edge_budget);
        int unsigned sent, graph_len;
        sent = 0;
        while (sent < edge_budget)
        begin
            graph_len = ($urandom_range(0, 15) == 0) ? $urandom_range(60, 150)
                                                     : $urandom_range(1, 25);
            for (int i = 0; i < graph_len; i++)
                send_edge(pick_node(), pick_node(), pick_weight(), i == graph_len - 1);
            sent += graph_len;
        end
    endtask

    initial
    begin
        rst_n               = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        edge_if.valid       = 1'b0;
        edge_if.first_node  = '0;
        edge_if.second_node = '0;
        edge_if.edge_weight = '0;
        edge_if.last_edge   = 1'b0;
        repeat (5) @(posedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed, reset node count: extremes, self loop, disconnected forest
        send_edge(10'd0, 10'd1023, 16'sh7fff, 1'b0);
        send_edge(10'd1023, 10'd0, 16'sh8000, 1'b0);
        send_edge(10'd5, 10'd5, 16'sh8000, 1'b0);
        send_edge(10'd0, 10'd1023, 16'sh0000, 1'b1);
        send_edge(10'd7, 10'd7, -16'sd3, 1'b1);          // only a self loop
        send_edge(10'd1, 10'd2, -16'sd100, 1'b0);        // two separate components
        send_edge(10'd3, 10'd4, 16'sd200, 1'b0);
        send_edge(10'd2, 10'd1, 16'sd50, 1'b1);
        send_edge(10'd682, 10'd341, 16'sh5555, 1'b1);
        drain_results();

        // a single node: every edge with a nonzero endpoint drops, graph can be empty
        write_node_count(32'd1);
        send_edge(10'd0, 10'd0, 16'sd9, 1'b0);
        send_edge(10'd1, 10'd0, 16'sd9, 1'b1);
        send_edge(10'd0, 10'd1, 16'sd4, 1'b1);           // dropped, nothing stored
        drain_results();

        // zero nodes drop every edge
        write_node_count(32'd0);
        send_edge(10'd0, 10'd0, 16'sd1, 1'b0);
        send_edge(10'd3, 10'd2, 16'sd1, 1'b1);
        drain_results();

        // counts above the node range act as the maximum; upper bits are ignored
        write_node_count(32'hffff_ffff);
        send_edge(10'd1023, 10'd1022, -16'sd1, 1'b0);
        send_edge(10'd1022, 10'd1021, -16'sd2, 1'b1);
        drain_results();

        // random phases over several node counts
        write_node_count(32'd1024);
        random_graphs(250);
        // long receiver hold-off while small graphs keep coming
        hold_request = 1;
        for (int i = 0; i < 12; i++)
            send_edge(pick_node(), pick_node(), pick_weight(), i % 3 == 2);
        random_graphs(100);
        drain_results();

        write_node_count(32'd300);
        random_graphs(200);
        drain_results();

        write_node_count(32'd5);
        random_graphs(150);
        drain_results();

        write_node_count(32'd1);
        random_graphs(40);
        drain_results();

        write_node_count(32'd2047);
        random_graphs(150);
        drain_results();

        repeat (50) @(posedge clk);
        if (sb.error_count == 0 && sb.pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
